>>> hw/rtl/sksc_pkg.sv
// ----------------------------------------------------------------------------
// sksc_pkg
// Shared types and constants for the salted keystream byte cipher.
// ----------------------------------------------------------------------------
package sksc_pkg;

  localparam int KEY_BYTES  = 16;
  localparam int SALT_BYTES = 8;
  localparam int CFG_WIDTH  = 64;
  localparam int CFG_IDX_W  = 2;

  typedef logic [7:0] byte_t;
  typedef logic [7:0] pos_t;
  typedef logic [CFG_WIDTH-1:0] cfg_word_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SALT     = 2'd0,
    REG_KEY_LOW  = 2'd1,
    REG_KEY_HIGH = 2'd2
  } reg_idx_t;

  // Salt and key held as byte arrays; element k sits in bits 8k+7 down to 8k.
  typedef struct packed {
    logic [SALT_BYTES-1:0][7:0] salt;
    logic [KEY_BYTES-1:0][7:0]  key;
  } cfg_t;

endpackage

>>> hw/rtl/sksc_cfg.sv
// ----------------------------------------------------------------------------
// sksc_cfg
// Configuration registers for salt and master key, written by index.
// ----------------------------------------------------------------------------
module sksc_cfg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  sksc_pkg::cfg_idx_t    wr_index,
  input  sksc_pkg::cfg_word_t   wr_data,
  output sksc_pkg::cfg_t        cfg
);
  import sksc_pkg::*;

  cfg_word_t salt_bytes;
  cfg_word_t key_low;
  cfg_word_t key_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      salt_bytes <= '0;
      key_low    <= '0;
      key_high   <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_SALT:     salt_bytes <= wr_data;
        REG_KEY_LOW:  key_low    <= wr_data;
        REG_KEY_HIGH: key_high   <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg.salt = salt_bytes;
  assign cfg.key  = {key_high, key_low};

endmodule

>>> hw/rtl/sksc_keystream.sv
// ----------------------------------------------------------------------------
// sksc_keystream
// Keystream byte for one position, XORed onto the message byte.
// ----------------------------------------------------------------------------
module sksc_keystream (
  input  sksc_pkg::cfg_t  cfg,
  input  sksc_pkg::pos_t  pos,
  input  sksc_pkg::byte_t data_byte,
  output sksc_pkg::byte_t cipher_byte
);
  import sksc_pkg::*;

  byte_t       s;
  byte_t       mixed;
  logic [2:0]  rot_amt;
  logic [15:0] rot_wide;
  byte_t       rotated;
  logic [2:0]  salt2_idx;
  byte_t       pos_term;
  byte_t       key2_sum;
  byte_t       ks;

  always_comb begin
    s         = cfg.salt[pos[2:0]];
    mixed     = cfg.key[pos[3:0]] ^ s;
    rot_amt   = pos[2:0] + s[2:0];
    rot_wide  = {mixed, mixed} << rot_amt;
    rotated   = rot_wide[15:8];
    // pos*7 mod 8 equals the negated low three bits of pos.
    salt2_idx = 3'd0 - pos[2:0];
    // pos*31 mod 256 as (pos << 5) - pos.
    pos_term  = {pos[2:0], 5'd0} - pos + cfg.salt[salt2_idx];
    key2_sum  = {pos[6:0], 1'b0} + pos + s;
    ks        = rotated ^ pos_term ^ cfg.key[key2_sum[3:0]];
    cipher_byte = data_byte ^ ks;
  end

endmodule

>>> hw/rtl/salted_keystream_byte_cipher_top.sv
// ----------------------------------------------------------------------------
// salted_keystream_byte_cipher_top
// Byte stream cipher: XOR with a salt- and key-dependent keystream.
// ----------------------------------------------------------------------------
// Usage:
//   Message bytes enter on the in_valid/in_ready channel with data_byte and
//   is_last; results leave on out_valid/out_ready with cipher_byte and
//   end_of_message. Each transfer in yields exactly one transfer out, in order.
//   Encryption and decryption are the same operation. Salt and key are written
//   through wr_en/wr_index/wr_data while idle; the user must ensure this, as
//   the block does not enforce it. The input register holds the byte and its
//   position, and the keystream logic feeds the output register. Throughput is
//   one byte per cycle while out_ready is high, set by the single keystream
//   stage between those registers. The byte position counts transfers mod 256
//   and returns to zero after a byte marked last.
//   Reset clears the salt, key, position and both valid flags.
//   When the receiver stalls, the output register holds its result and the
//   input register takes one more byte if empty, and in_ready then stays low.
// ----------------------------------------------------------------------------
module salted_keystream_byte_cipher_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  sksc_pkg::cfg_idx_t  wr_index,
  input  sksc_pkg::cfg_word_t wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  sksc_pkg::byte_t     data_byte,
  input  logic                is_last,
  output logic                out_valid,
  input  logic                out_ready,
  output sksc_pkg::byte_t     cipher_byte,
  output logic                end_of_message
);
  import sksc_pkg::*;

  cfg_t  cfg;
  pos_t  byte_position;
  logic  s1_valid;
  byte_t s1_data;
  logic  s1_last;
  pos_t  s1_pos;
  logic  s1_advance;
  byte_t ks_result;

  sksc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      byte_position <= '0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid      <= 1'b1;
        byte_position <= is_last ? '0 : byte_position + 8'd1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= data_byte;
      s1_last <= is_last;
      s1_pos  <= byte_position;
    end
  end

  sksc_keystream u_keystream (
    .cfg         (cfg),
    .pos         (s1_pos),
    .data_byte   (s1_data),
    .cipher_byte (ks_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      cipher_byte    <= ks_result;
      end_of_message <= s1_last;
    end
  end

endmodule
